// ===== sv/tli_pkg.sv =====
// Shared types, constants and saturation helper for the Lagrange interpolator.
`default_nettype none

package tli_pkg;

    localparam int MAX_POINTS_DEF = 4;
    localparam int MAX_DIMS_DEF   = 4;
    localparam int DATA_W         = 32;
    localparam int NUM_W          = 49;
    localparam int DEN_W          = 33;
    localparam int TAB_AW         = 8;
    localparam int CFG_W          = 3;

    localparam logic signed [DATA_W-1:0] Q_ONE  = 32'sh0001_0000;
    localparam logic signed [63:0]       SAT_HI = 64'sd2147483647;
    localparam logic signed [63:0]       SAT_LO = -64'sd2147483648;

    typedef enum logic [1:0] {
        ACT_LOAD_GRID  = 2'd0,
        ACT_LOAD_TABLE = 2'd1,
        ACT_EVAL       = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        REG_NUM_DIMS     = 3'd0,
        REG_POINTS_ONE   = 3'd1,
        REG_POINTS_TWO   = 3'd2,
        REG_POINTS_THREE = 3'd3,
        REG_POINTS_FOUR  = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        ARITH_MUL = 1'b0,
        ARITH_DIV = 1'b1
    } arith_op_t;

    typedef struct packed {
        logic                     start;
        arith_op_t                op;
        logic signed [NUM_W-1:0]  opa;
        logic signed [DEN_W-1:0]  opb;
    } arith_req_t;

    typedef struct packed {
        logic                     busy;
        logic                     done;
        logic signed [DATA_W-1:0] result;
    } arith_rsp_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_HI) begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < SAT_LO) begin
            r = 32'sh8000_0000;
        end
        else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/tli_arith.sv =====
// Shared arithmetic unit: Q16.16 multiply and bit-serial saturating divide.
`default_nettype none

module tli_arith (
    input  wire                 clk,
    input  wire                 rst_n,
    input  tli_pkg::arith_req_t req,
    output tli_pkg::arith_rsp_t rsp
);
    import tli_pkg::*;

    localparam int STEP_W = $clog2(NUM_W);
    localparam logic [NUM_W-1:0] QMAG_NEG = NUM_W'(64'd2147483648);
    localparam logic [NUM_W-1:0] QMAG_POS = NUM_W'(64'd2147483647);

    typedef enum logic [3:0] {
        A_IDLE = 4'b0001,
        A_MUL  = 4'b0010,
        A_DIV  = 4'b0100,
        A_FIN  = 4'b1000
    } astate_t;

    astate_t                  state_reg, state_next;
    logic signed [63:0]       prod_reg, prod_next;
    logic [NUM_W-1:0]         quo_reg, quo_next;
    logic [DEN_W-1:0]         den_reg, den_next;
    logic [DEN_W-1:0]         rem_reg, rem_next;
    logic                     neg_reg, neg_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic signed [DATA_W-1:0] res_reg, res_next;
    logic                     done_reg, done_next;

    logic [DEN_W:0]           trial;
    logic [DEN_W:0]           diff;
    logic [NUM_W-1:0]         num_abs;
    logic [DEN_W-1:0]         den_abs;

    assign num_abs = req.opa[NUM_W-1] ? NUM_W'(-req.opa) : NUM_W'(req.opa);
    assign den_abs = req.opb[DEN_W-1] ? DEN_W'(-req.opb) : DEN_W'(req.opb);
    assign trial   = {rem_reg, quo_reg[NUM_W-1]};
    assign diff    = trial - {1'b0, den_reg};

    always_comb begin
        state_next = state_reg;
        prod_next  = prod_reg;
        quo_next   = quo_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        step_next  = step_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            A_IDLE:
            begin
                if (req.start) begin
                    if (req.op == ARITH_MUL) begin
                        prod_next  = 64'($signed(req.opa[DATA_W-1:0]))
                                     * 64'($signed(req.opb[DATA_W-1:0]));
                        state_next = A_MUL;
                    end
                    else begin
                        quo_next   = num_abs;
                        den_next   = den_abs;
                        rem_next   = '0;
                        neg_next   = req.opa[NUM_W-1] ^ req.opb[DEN_W-1];
                        step_next  = STEP_W'(NUM_W - 1);
                        state_next = A_DIV;
                    end
                end
            end
            A_MUL:
            begin
                res_next   = sat32(prod_reg >>> 16);
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            A_DIV:
            begin
                // One quotient bit per cycle, restoring form on magnitudes.
                if (!diff[DEN_W]) begin
                    rem_next = diff[DEN_W-1:0];
                    quo_next = {quo_reg[NUM_W-2:0], 1'b1};
                end
                else begin
                    rem_next = trial[DEN_W-1:0];
                    quo_next = {quo_reg[NUM_W-2:0], 1'b0};
                end
                if (step_reg == '0) begin
                    state_next = A_FIN;
                end
                else begin
                    step_next = step_reg - 1'b1;
                end
            end
            A_FIN:
            begin
                if (neg_reg) begin
                    res_next = (quo_reg > QMAG_NEG) ? 32'sh8000_0000
                                                    : -$signed(quo_reg[DATA_W-1:0]);
                end
                else begin
                    res_next = (quo_reg > QMAG_POS) ? 32'sh7FFF_FFFF
                                                    : $signed(quo_reg[DATA_W-1:0]);
                end
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= A_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk) begin
        prod_reg <= prod_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
        res_reg  <= res_next;
    end

    assign rsp.busy   = (state_reg != A_IDLE);
    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

`default_nettype wire

// ===== sv/tli_seq.sv =====
// Sequencer with grid, table and work memories; drives the shared arithmetic unit.
`default_nettype none

module tli_seq #(
    parameter int MAX_POINTS = tli_pkg::MAX_POINTS_DEF,
    parameter int MAX_DIMS   = tli_pkg::MAX_DIMS_DEF
) (
    input  wire                                                 clk,
    input  wire                                                 rst_n,
    input  wire                                                 in_valid,
    output logic                                                in_stall,
    input  wire  [1:0]                                          action,
    input  wire  [1:0]                                          axis_select,
    input  wire  [1:0]                                          point_index,
    input  wire  [7:0]                                          table_index,
    input  wire  signed [31:0]                                  load_data,
    input  wire  signed [31:0]                                  query_one,
    input  wire  signed [31:0]                                  query_two,
    input  wire  signed [31:0]                                  query_three,
    input  wire  signed [31:0]                                  query_four,
    input  wire  [$clog2(MAX_DIMS+1)-1:0]                       dims_use,
    input  wire  [MAX_DIMS-1:0][$clog2(MAX_POINTS+1)-1:0]       counts,
    output logic                                                res_valid,
    input  wire                                                 res_take,
    output logic signed [31:0]                                  res_value,
    output logic                                                res_err,
    output tli_pkg::arith_req_t                                 areq,
    input  tli_pkg::arith_rsp_t                                 arsp
);
    import tli_pkg::*;

    localparam int CW     = $clog2(MAX_POINTS + 1);
    localparam int PW     = $clog2(MAX_POINTS);
    localparam int DW     = $clog2(MAX_DIMS + 1);
    localparam int AXW    = $clog2(MAX_DIMS);
    localparam int GDEPTH = MAX_DIMS * MAX_POINTS;
    localparam int GAW    = $clog2(GDEPTH);
    localparam int WDEPTH = MAX_POINTS ** (MAX_DIMS - 1);
    localparam int WAW    = $clog2(WDEPTH);
    localparam int TW     = $clog2(MAX_POINTS ** MAX_DIMS + 1);
    localparam int TDEPTH = 2 ** TAB_AW;

    typedef enum logic [13:0] {
        S_IDLE     = 14'h0001,
        S_CHK_RD   = 14'h0002,
        S_CHK_CMP  = 14'h0004,
        S_W_GI     = 14'h0008,
        S_W_GIL    = 14'h0010,
        S_W_JSEL   = 14'h0020,
        S_W_GJ     = 14'h0040,
        S_W_DIVST  = 14'h0080,
        S_W_DIVW   = 14'h0100,
        S_W_MULW   = 14'h0200,
        S_C_RD     = 14'h0400,
        S_C_MULST  = 14'h0800,
        S_C_MULW   = 14'h1000,
        S_DONE     = 14'h2000
    } sstate_t;

    function automatic logic [GAW-1:0] gaddr(input int ax, input int pt);
        return GAW'(ax * MAX_POINTS + pt);
    endfunction

    function automatic logic [TW-1:0] rest_after(
        input logic [AXW-1:0]                ax,
        input logic [DW-1:0]                 dims,
        input logic [MAX_DIMS-1:0][CW-1:0]   cnt
    );
        logic [TW-1:0] p;
        p = TW'(1);
        for (int b = 0; b < MAX_DIMS; b++) begin
            if (b > int'(ax) && b < int'(dims)) begin
                p = TW'(p * cnt[b]);
            end
        end
        return p;
    endfunction

    sstate_t                  state_reg, state_next;
    logic [AXW-1:0]           ax_reg, ax_next;
    logic [CW-1:0]            i_reg, i_next;
    logic [CW-1:0]            j_reg, j_next;
    logic [TW-1:0]            r_reg, r_next;
    logic [TW-1:0]            base_reg, base_next;
    logic signed [31:0]       gi_reg, gi_next;
    logic signed [31:0]       p_reg, p_next;
    logic signed [31:0]       acc_reg, acc_next;
    logic signed [31:0]       w_reg [MAX_POINTS];
    logic signed [31:0]       w_next [MAX_POINTS];
    logic signed [31:0]       pts_reg [MAX_POINTS];
    logic signed [31:0]       pts_next [MAX_POINTS];
    logic signed [31:0]       q_reg [MAX_DIMS];
    logic signed [31:0]       q_next [MAX_DIMS];
    logic signed [31:0]       rv_reg, rv_next;
    logic                     re_reg, re_next;

    logic signed [31:0]       grid_mem [GDEPTH];
    logic signed [31:0]       tab_mem [TDEPTH];
    logic signed [31:0]       work_mem [WDEPTH];
    logic signed [31:0]       grid_q, tab_q, work_q;

    logic                     in_acc;
    logic                     grid_we, tab_we, work_we;
    logic [GAW-1:0]           grid_waddr, grid_raddr;
    logic [CW-1:0]            rd_pt;
    logic [TW-1:0]            src_idx;
    logic [CW-1:0]            n_cur;
    logic [TW-1:0]            rest_cur;
    logic                     ax_more;
    logic                     hit;
    logic signed [31:0]       qin [4];
    logic signed [31:0]       x_cur;
    logic signed [31:0]       src_data;
    logic signed [DEN_W-1:0]  xdiff;
    logic signed [DEN_W-1:0]  gdiff;
    logic signed [63:0]       acc_wide;
    logic signed [31:0]       acc_sum;

    assign qin[0] = query_one;
    assign qin[1] = query_two;
    assign qin[2] = query_three;
    assign qin[3] = query_four;

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;

    assign grid_we    = in_acc && (action == ACT_LOAD_GRID)
                        && (int'(axis_select) < MAX_DIMS) && (int'(point_index) < MAX_POINTS);
    assign grid_waddr = gaddr(int'(axis_select), int'(point_index));
    assign tab_we     = in_acc && (action == ACT_LOAD_TABLE);

    assign rd_pt      = (state_reg == S_W_GI) ? i_reg : j_reg;
    assign grid_raddr = gaddr(int'(ax_reg), int'(rd_pt));
    assign src_idx    = base_reg + TW'(i_reg);

    assign n_cur    = counts[ax_reg];
    assign rest_cur = rest_after(ax_reg, dims_use, counts);
    assign ax_more  = (DW'(ax_reg) + 1'b1) < dims_use;
    assign x_cur    = q_reg[ax_reg];
    assign src_data = (ax_reg == '0) ? tab_q : work_q;

    assign xdiff    = DEN_W'(x_cur) - DEN_W'(grid_q);
    assign gdiff    = DEN_W'(gi_reg) - DEN_W'(grid_q);
    assign acc_wide = 64'(acc_reg) + 64'(arsp.result);
    assign acc_sum  = sat32(acc_wide);

    // A new grid point is checked against every earlier point of its axis at once.
    always_comb begin
        hit = 1'b0;
        for (int k = 0; k < MAX_POINTS; k++) begin
            if (k < int'(j_reg) && pts_reg[k] == grid_q) begin
                hit = 1'b1;
            end
        end
    end

    always_comb begin
        areq.start = 1'b0;
        areq.op    = ARITH_MUL;
        areq.opa   = '0;
        areq.opb   = '0;
        if (state_reg == S_W_DIVST) begin
            areq.start = 1'b1;
            areq.op    = ARITH_DIV;
            areq.opa   = {xdiff, 16'h0000};
            areq.opb   = gdiff;
        end
        else if (state_reg == S_W_DIVW && arsp.done) begin
            areq.start = 1'b1;
            areq.opa   = NUM_W'(p_reg);
            areq.opb   = DEN_W'(arsp.result);
        end
        else if (state_reg == S_C_MULST) begin
            areq.start = 1'b1;
            areq.opa   = NUM_W'(src_data);
            areq.opb   = DEN_W'(w_reg[i_reg[PW-1:0]]);
        end
    end

    always_comb begin
        state_next = state_reg;
        ax_next    = ax_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        r_next     = r_reg;
        base_next  = base_reg;
        gi_next    = gi_reg;
        p_next     = p_reg;
        acc_next   = acc_reg;
        w_next     = w_reg;
        pts_next   = pts_reg;
        q_next     = q_reg;
        rv_next    = rv_reg;
        re_next    = re_reg;
        work_we    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && action == ACT_EVAL) begin
                    for (int k = 0; k < MAX_DIMS; k++) begin
                        q_next[k] = qin[k];
                    end
                    ax_next    = '0;
                    j_next     = '0;
                    state_next = S_CHK_RD;
                end
            end
            S_CHK_RD:
            begin
                state_next = S_CHK_CMP;
            end
            S_CHK_CMP:
            begin
                if (hit) begin
                    rv_next    = '0;
                    re_next    = 1'b1;
                    state_next = S_DONE;
                end
                else begin
                    pts_next[j_reg[PW-1:0]] = grid_q;
                    if ((j_reg + 1'b1) < n_cur) begin
                        j_next     = j_reg + 1'b1;
                        state_next = S_CHK_RD;
                    end
                    else if (ax_more) begin
                        ax_next    = ax_reg + 1'b1;
                        j_next     = '0;
                        state_next = S_CHK_RD;
                    end
                    else begin
                        ax_next    = '0;
                        i_next     = '0;
                        state_next = S_W_GI;
                    end
                end
            end
            S_W_GI:
            begin
                state_next = S_W_GIL;
            end
            S_W_GIL:
            begin
                gi_next    = grid_q;
                p_next     = Q_ONE;
                j_next     = '0;
                state_next = S_W_JSEL;
            end
            S_W_JSEL:
            begin
                if (j_reg == n_cur) begin
                    w_next[i_reg[PW-1:0]] = p_reg;
                    if ((i_reg + 1'b1) < n_cur) begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_W_GI;
                    end
                    else begin
                        i_next     = '0;
                        r_next     = '0;
                        base_next  = '0;
                        acc_next   = '0;
                        state_next = S_C_RD;
                    end
                end
                else if (j_reg == i_reg) begin
                    j_next = j_reg + 1'b1;
                end
                else begin
                    state_next = S_W_GJ;
                end
            end
            S_W_GJ:
            begin
                state_next = S_W_DIVST;
            end
            S_W_DIVST:
            begin
                state_next = S_W_DIVW;
            end
            S_W_DIVW:
            begin
                if (arsp.done) begin
                    state_next = S_W_MULW;
                end
            end
            S_W_MULW:
            begin
                if (arsp.done) begin
                    p_next     = arsp.result;
                    j_next     = j_reg + 1'b1;
                    state_next = S_W_JSEL;
                end
            end
            S_C_RD:
            begin
                state_next = S_C_MULST;
            end
            S_C_MULST:
            begin
                state_next = S_C_MULW;
            end
            S_C_MULW:
            begin
                if (arsp.done) begin
                    if ((i_reg + 1'b1) < n_cur) begin
                        acc_next   = acc_sum;
                        i_next     = i_reg + 1'b1;
                        state_next = S_C_RD;
                    end
                    else begin
                        // The contracted value lands at a slot that no later read needs.
                        work_we = 1'b1;
                        if ((r_reg + 1'b1) < rest_cur) begin
                            r_next     = r_reg + 1'b1;
                            base_next  = base_reg + TW'(n_cur);
                            i_next     = '0;
                            acc_next   = '0;
                            state_next = S_C_RD;
                        end
                        else if (ax_more) begin
                            ax_next    = ax_reg + 1'b1;
                            i_next     = '0;
                            state_next = S_W_GI;
                        end
                        else begin
                            rv_next    = acc_sum;
                            re_next    = 1'b0;
                            state_next = S_DONE;
                        end
                    end
                end
            end
            S_DONE:
            begin
                if (res_take) begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            ax_reg    <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            r_reg     <= '0;
            base_reg  <= '0;
        end
        else begin
            state_reg <= state_next;
            ax_reg    <= ax_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            r_reg     <= r_next;
            base_reg  <= base_next;
        end
    end

    always_ff @(posedge clk) begin
        gi_reg  <= gi_next;
        p_reg   <= p_next;
        acc_reg <= acc_next;
        w_reg   <= w_next;
        pts_reg <= pts_next;
        q_reg   <= q_next;
        rv_reg  <= rv_next;
        re_reg  <= re_next;
    end

    always_ff @(posedge clk) begin
        if (grid_we) begin
            grid_mem[grid_waddr] <= load_data;
        end
        grid_q <= grid_mem[grid_raddr];
    end

    always_ff @(posedge clk) begin
        if (tab_we) begin
            tab_mem[table_index] <= load_data;
        end
        tab_q <= tab_mem[TAB_AW'(src_idx)];
    end

    always_ff @(posedge clk) begin
        if (work_we) begin
            work_mem[WAW'(r_reg)] <= acc_sum;
        end
        work_q <= work_mem[WAW'(src_idx)];
    end

    assign res_valid = (state_reg == S_DONE);
    assign res_value = rv_reg;
    assign res_err   = re_reg;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_err) |-> (res_value == '0))
        else $error("grid error result carries a nonzero value");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        areq.start |-> !arsp.busy)
        else $error("arithmetic unit started while busy");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_C_RD) |-> ((i_reg < n_cur) && (r_reg < rest_cur)))
        else $error("contraction index out of range");

endmodule

`default_nettype wire

// ===== sv/tensor_lagrange_interpolator.sv =====
// Top level: configuration registers, output register and the sequencer with its shared unit.
// Tensor-product Lagrange interpolator in signed Q16.16 over 2 to MAX_DIMS axes. Load
// transfers (grid coordinate or table value) are written as they are accepted and do not
// cause a stall. An evaluate transfer first checks every used axis for coincident grid
// points, then for each axis computes the basis weights and contracts the table. Each
// Lagrange factor is a divide in the bit-serial divider of the shared arithmetic unit,
// which works one quotient bit per cycle, followed by a multiply; each contracted term
// goes through the same unit's multiplier. The input is stalled while an evaluate is in
// progress; one finished result is held in the output register so the next transfer can
// be taken while it waits. Memories need no clearing pass after reset.
`default_nettype none

module tensor_lagrange_interpolator #(
    parameter int MAX_POINTS = tli_pkg::MAX_POINTS_DEF,
    parameter int MAX_DIMS   = tli_pkg::MAX_DIMS_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_stall,
    input  wire  [1:0]                   action,
    input  wire  [1:0]                   axis_select,
    input  wire  [1:0]                   point_index,
    input  wire  [7:0]                   table_index,
    input  wire  signed [31:0]           load_data,
    input  wire  signed [31:0]           query_one,
    input  wire  signed [31:0]           query_two,
    input  wire  signed [31:0]           query_three,
    input  wire  signed [31:0]           query_four,
    output logic                         out_valid,
    input  wire                          out_stall,
    output logic signed [31:0]           interp_value,
    output logic                         grid_error,
    input  wire                          cfg_write,
    input  wire  [2:0]                   cfg_index,
    input  wire  [tli_pkg::CFG_W-1:0]    cfg_data
);
    import tli_pkg::*;

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int DW = $clog2(MAX_DIMS + 1);

    logic [CFG_W-1:0]               num_dims_reg;
    logic [CFG_W-1:0]               pts_cfg_reg [4];
    logic [DW-1:0]                  dims_use;
    logic [MAX_DIMS-1:0][CW-1:0]    counts;

    logic                           res_valid;
    logic                           res_take;
    logic signed [31:0]             res_value;
    logic                           res_err;
    arith_req_t                     areq;
    arith_rsp_t                     arsp;

    logic                           out_valid_reg;
    logic signed [31:0]             out_value_reg;
    logic                           out_err_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            num_dims_reg <= CFG_W'(2);
            for (int k = 0; k < 4; k++) begin
                pts_cfg_reg[k] <= CFG_W'(4);
            end
        end
        else if (cfg_write) begin
            unique case (cfg_index)
                REG_NUM_DIMS:     num_dims_reg   <= cfg_data;
                REG_POINTS_ONE:   pts_cfg_reg[0] <= cfg_data;
                REG_POINTS_TWO:   pts_cfg_reg[1] <= cfg_data;
                REG_POINTS_THREE: pts_cfg_reg[2] <= cfg_data;
                REG_POINTS_FOUR:  pts_cfg_reg[3] <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Out-of-range settings are pulled into the supported range.
    always_comb begin
        if (int'(num_dims_reg) < 2) begin
            dims_use = DW'(2);
        end
        else if (int'(num_dims_reg) > MAX_DIMS) begin
            dims_use = DW'(MAX_DIMS);
        end
        else begin
            dims_use = DW'(num_dims_reg);
        end
        for (int k = 0; k < MAX_DIMS; k++) begin
            if (pts_cfg_reg[k] == '0) begin
                counts[k] = CW'(1);
            end
            else if (int'(pts_cfg_reg[k]) > MAX_POINTS) begin
                counts[k] = CW'(MAX_POINTS);
            end
            else begin
                counts[k] = CW'(pts_cfg_reg[k]);
            end
        end
    end

    tli_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (areq),
        .rsp   (arsp)
    );

    tli_seq #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_DIMS   (MAX_DIMS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .axis_select (axis_select),
        .point_index (point_index),
        .table_index (table_index),
        .load_data   (load_data),
        .query_one   (query_one),
        .query_two   (query_two),
        .query_three (query_three),
        .query_four  (query_four),
        .dims_use    (dims_use),
        .counts      (counts),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res_value   (res_value),
        .res_err     (res_err),
        .areq        (areq),
        .arsp        (arsp)
    );

    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take) begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (res_take) begin
            out_value_reg <= res_value;
            out_err_reg   <= res_err;
        end
    end

    assign out_valid    = out_valid_reg;
    assign interp_value = out_value_reg;
    assign grid_error   = out_err_reg;

endmodule

`default_nettype wire
